@@ rtl/bpc_pkg.sv @@
// Shared types, codes and the microprogram of the barometer compensation unit.
// Used by bpc_fpu.sv and baro_temp_pressure_compensation_unit.sv; no dependencies.

package bpc_pkg;

   // Operations of the shared binary32 unit.
   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } fpu_op_type;

   // Operand sources: converted raw reading, stored linear temperature,
   // calibration coefficients and six scratch registers.
   typedef enum logic [4:0] {
      SRC_RAW,
      SRC_LIN,
      SRC_T1,
      SRC_T2,
      SRC_T3,
      SRC_P1,
      SRC_P2,
      SRC_P3,
      SRC_P4,
      SRC_P5,
      SRC_P6,
      SRC_P7,
      SRC_P8,
      SRC_P9,
      SRC_P10,
      SRC_P11,
      SRC_RA,
      SRC_RB,
      SRC_RC,
      SRC_RD,
      SRC_RE,
      SRC_RF
   } src_type;

   typedef enum logic [2:0] {
      DST_RA,
      DST_RB,
      DST_RC,
      DST_RD,
      DST_RE,
      DST_RF,
      DST_LIN
   } dst_type;

   typedef struct packed {
      fpu_op_type op;
      src_type    src_a;
      src_type    src_b;
      dst_type    dst;
      logic       last;
   } step_type;

   // Issue bundle from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic       valid;
      fpu_op_type op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_OUT
   } seq_state_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_T1_T2   = 3'd0;
   localparam logic [2:0] CSR_T3_P1   = 3'd1;
   localparam logic [2:0] CSR_P2_P3   = 3'd2;
   localparam logic [2:0] CSR_P4_P5   = 3'd3;
   localparam logic [2:0] CSR_P6_P7   = 3'd4;
   localparam logic [2:0] CSR_P8_P9   = 3'd5;
   localparam logic [2:0] CSR_P10_P11 = 3'd6;

   // Program entry points.
   localparam logic [4:0] PC_TEMP = 5'd0;
   localparam logic [4:0] PC_PRES = 5'd8;

   // Microprogram. Temperature at PC_TEMP, pressure at PC_PRES.
   function automatic step_type prog_step(input logic [4:0] pc);
      step_type s;
      unique case (pc)
         5'd0:  s = '{OP_SUB, SRC_RAW, SRC_T1,  DST_RA,  1'b0}; // d
         5'd1:  s = '{OP_MUL, SRC_RA,  SRC_T2,  DST_RB,  1'b0}; // d*t2
         5'd2:  s = '{OP_MUL, SRC_RA,  SRC_RA,  DST_RC,  1'b0}; // d*d
         5'd3:  s = '{OP_MUL, SRC_RC,  SRC_T3,  DST_RC,  1'b0};
         5'd4:  s = '{OP_ADD, SRC_RB,  SRC_RC,  DST_LIN, 1'b1};
         5'd8:  s = '{OP_MUL, SRC_LIN, SRC_LIN, DST_RA,  1'b0}; // tt
         5'd9:  s = '{OP_MUL, SRC_RA,  SRC_LIN, DST_RB,  1'b0}; // ttt
         5'd10: s = '{OP_MUL, SRC_P6,  SRC_LIN, DST_RC,  1'b0};
         5'd11: s = '{OP_ADD, SRC_P5,  SRC_RC,  DST_RD,  1'b0};
         5'd12: s = '{OP_MUL, SRC_P7,  SRC_RA,  DST_RC,  1'b0};
         5'd13: s = '{OP_ADD, SRC_RD,  SRC_RC,  DST_RD,  1'b0};
         5'd14: s = '{OP_MUL, SRC_P8,  SRC_RB,  DST_RC,  1'b0};
         5'd15: s = '{OP_ADD, SRC_RD,  SRC_RC,  DST_RD,  1'b0}; // o1
         5'd16: s = '{OP_MUL, SRC_P2,  SRC_LIN, DST_RC,  1'b0};
         5'd17: s = '{OP_ADD, SRC_P1,  SRC_RC,  DST_RE,  1'b0};
         5'd18: s = '{OP_MUL, SRC_P3,  SRC_RA,  DST_RC,  1'b0};
         5'd19: s = '{OP_ADD, SRC_RE,  SRC_RC,  DST_RE,  1'b0};
         5'd20: s = '{OP_MUL, SRC_P4,  SRC_RB,  DST_RC,  1'b0};
         5'd21: s = '{OP_ADD, SRC_RE,  SRC_RC,  DST_RE,  1'b0};
         5'd22: s = '{OP_MUL, SRC_RAW, SRC_RE,  DST_RF,  1'b0}; // o2
         5'd23: s = '{OP_MUL, SRC_RAW, SRC_RAW, DST_RA,  1'b0}; // rr
         5'd24: s = '{OP_MUL, SRC_RA,  SRC_RAW, DST_RB,  1'b0}; // rrr
         5'd25: s = '{OP_MUL, SRC_P10, SRC_LIN, DST_RC,  1'b0};
         5'd26: s = '{OP_ADD, SRC_P9,  SRC_RC,  DST_RE,  1'b0};
         5'd27: s = '{OP_MUL, SRC_RA,  SRC_RE,  DST_RE,  1'b0};
         5'd28: s = '{OP_MUL, SRC_RB,  SRC_P11, DST_RC,  1'b0};
         5'd29: s = '{OP_ADD, SRC_RE,  SRC_RC,  DST_RE,  1'b0}; // o3
         5'd30: s = '{OP_ADD, SRC_RD,  SRC_RF,  DST_RD,  1'b0};
         5'd31: s = '{OP_ADD, SRC_RD,  SRC_RE,  DST_RD,  1'b1};
         default: s = '{OP_ADD, SRC_RA, SRC_RA, DST_RA, 1'b1};
      endcase
      return s;
   endfunction

endpackage

@@ rtl/bpc_fpu.sv @@
// Four-stage binary32 add/subtract/multiply unit, round to nearest even,
// subnormals kept, NaN results canonical. Depends on bpc_pkg.

module bpc_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  bpc_pkg::fpu_req_type req,
   output logic                 done,
   output logic [31:0]          result
);

   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   // ---------------- stage 1: unpack, multiply or align and add
   logic              a_sign, b_sign;
   logic [7:0]        a_exp, b_exp, a_expe, b_expe;
   logic [22:0]       a_frac, b_frac;
   logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0]       a_man, b_man;
   logic [47:0]       prod;
   logic              a_ge;
   logic              x_sign, y_sign;
   logic [7:0]        x_exp, y_exp, diff;
   logic [23:0]       x_man, y_man;
   logic [5:0]        dsh;
   logic [49:0]       x_al, y_al, y_sh, m_add;
   logic              lost;
   logic              s1_nan_in, s1_inf_in, s1_sign_in, s1_valid_in;
   logic signed [10:0] s1_e_in;
   logic [49:0]       s1_m_in;

   logic              s1_valid_ff, s1_nan_ff, s1_inf_ff, s1_sign_ff;
   logic signed [10:0] s1_e_ff;
   logic [49:0]       s1_m_ff;

   always_comb begin
      a_sign = req.a[31];
      b_sign = req.b[31] ^ (req.op == bpc_pkg::OP_SUB);
      a_exp  = req.a[30:23];
      b_exp  = req.b[30:23];
      a_frac = req.a[22:0];
      b_frac = req.b[22:0];
      a_nan  = (a_exp == 8'hFF) && (a_frac != '0);
      b_nan  = (b_exp == 8'hFF) && (b_frac != '0);
      a_inf  = (a_exp == 8'hFF) && (a_frac == '0);
      b_inf  = (b_exp == 8'hFF) && (b_frac == '0);
      a_zero = (a_exp == 8'h00) && (a_frac == '0);
      b_zero = (b_exp == 8'h00) && (b_frac == '0);
      a_man  = {a_exp != 8'h00, a_frac};
      b_man  = {b_exp != 8'h00, b_frac};
      a_expe = (a_exp == 8'h00) ? 8'd1 : a_exp;
      b_expe = (b_exp == 8'h00) ? 8'd1 : b_exp;
      prod   = a_man * b_man;

      // order operands by magnitude for the adder
      a_ge   = req.a[30:0] >= req.b[30:0];
      x_sign = a_ge ? a_sign : b_sign;
      y_sign = a_ge ? b_sign : a_sign;
      x_exp  = a_ge ? a_expe : b_expe;
      y_exp  = a_ge ? b_expe : a_expe;
      x_man  = a_ge ? a_man : b_man;
      y_man  = a_ge ? b_man : a_man;
      diff   = x_exp - y_exp;
      dsh    = (diff > 8'd63) ? 6'd63 : diff[5:0];
      x_al   = {1'b0, x_man, 25'b0};
      y_al   = {1'b0, y_man, 25'b0};
      y_sh   = y_al >> dsh;
      lost   = |(y_al & ~({50{1'b1}} << dsh));
      y_sh[0] = y_sh[0] | lost;
      m_add  = (x_sign == y_sign) ? (x_al + y_sh) : (x_al - y_sh);

      s1_valid_in = req.valid;
      if (req.op == bpc_pkg::OP_MUL) begin
         s1_nan_in  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
         s1_inf_in  = a_inf || b_inf;
         s1_sign_in = a_sign ^ req.b[31];
         s1_e_in    = $signed({3'b0, a_expe}) + $signed({3'b0, b_expe}) - 11'sd127;
         s1_m_in    = {prod, 2'b00};
      end else begin
         s1_nan_in  = a_nan || b_nan || (a_inf && b_inf && (a_sign != b_sign));
         s1_inf_in  = a_inf || b_inf;
         s1_e_in    = $signed({3'b0, x_exp});
         s1_m_in    = m_add;
         // exact zero: +0 unless both addends are negative
         if (a_inf) begin
            s1_sign_in = a_sign;
         end else if (b_inf) begin
            s1_sign_in = b_sign;
         end else if (m_add == '0) begin
            s1_sign_in = x_sign & y_sign;
         end else begin
            s1_sign_in = x_sign;
         end
      end
   end

   // ---------------- stage 2: locate leading one, pick exponent and shift
   logic [5:0]        lead;
   logic signed [10:0] e_norm, e_fin, e_delta, e_mag;
   logic              s2_valid_in, s2_rsh_in;
   logic [5:0]        s2_amt_in;

   logic              s2_valid_ff, s2_nan_ff, s2_inf_ff, s2_sign_ff, s2_rsh_ff;
   logic signed [10:0] s2_e_ff;
   logic [5:0]        s2_amt_ff;
   logic [49:0]       s2_m_ff;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 50; i++) begin
         if (s1_m_ff[i]) begin
            lead = 6'(i);
         end
      end
      e_norm  = s1_e_ff + $signed({5'b0, lead}) - 11'sd48;
      e_fin   = (e_norm >= 11'sd1) ? e_norm : 11'sd1;
      e_delta = e_fin - s1_e_ff;
      e_mag   = (e_delta < 0) ? -e_delta : e_delta;
      s2_rsh_in   = e_delta > 0;
      s2_amt_in   = (e_mag > 11'sd63) ? 6'd63 : e_mag[5:0];
      s2_valid_in = s1_valid_ff;
   end

   // ---------------- stage 3: normalize or denormalize shift
   logic [49:0] s3_m_in;
   logic        s3_stk_in, s3_valid_in;

   logic              s3_valid_ff, s3_nan_ff, s3_inf_ff, s3_sign_ff, s3_stk_ff;
   logic signed [10:0] s3_e_ff;
   logic [49:0]       s3_m_ff;

   always_comb begin
      s3_valid_in = s2_valid_ff;
      if (s2_rsh_ff) begin
         s3_m_in   = s2_m_ff >> s2_amt_ff;
         s3_stk_in = |(s2_m_ff & ~({50{1'b1}} << s2_amt_ff));
      end else begin
         s3_m_in   = s2_m_ff << s2_amt_ff;
         s3_stk_in = 1'b0;
      end
   end

   // ---------------- stage 4: round and pack
   logic [23:0]       mant;
   logic              guard, sticky, round_up;
   logic [24:0]       mant_r;
   logic [23:0]       mant_f;
   logic signed [10:0] e_r;
   logic [7:0]        exp_f;
   logic [31:0]       result_in;

   logic        done_ff;
   logic [31:0] result_ff;

   always_comb begin
      mant     = s3_m_ff[48:25];
      guard    = s3_m_ff[24];
      sticky   = (|s3_m_ff[23:0]) | s3_stk_ff;
      round_up = guard & (sticky | mant[0]);
      mant_r   = {1'b0, mant} + {24'b0, round_up};
      if (mant_r[24]) begin
         e_r    = s3_e_ff + 11'sd1;
         mant_f = mant_r[24:1];
      end else begin
         e_r    = s3_e_ff;
         mant_f = mant_r[23:0];
      end
      exp_f = mant_f[23] ? e_r[7:0] : 8'h00;
      priority if (s3_nan_ff) begin
         result_in = QNAN;
      end else if (s3_inf_ff || (e_r >= 11'sd255)) begin
         result_in = {s3_sign_ff, 8'hFF, 23'b0};
      end else begin
         result_in = {s3_sign_ff, exp_f, mant_f[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         done_ff     <= s3_valid_ff;
      end
      s1_nan_ff  <= s1_nan_in;
      s1_inf_ff  <= s1_inf_in;
      s1_sign_ff <= s1_sign_in;
      s1_e_ff    <= s1_e_in;
      s1_m_ff    <= s1_m_in;
      s2_nan_ff  <= s1_nan_ff;
      s2_inf_ff  <= s1_inf_ff;
      s2_sign_ff <= s1_sign_ff;
      s2_e_ff    <= e_fin;
      s2_rsh_ff  <= s2_rsh_in;
      s2_amt_ff  <= s2_amt_in;
      s2_m_ff    <= s1_m_ff;
      s3_nan_ff  <= s2_nan_ff;
      s3_inf_ff  <= s2_inf_ff;
      s3_sign_ff <= s2_sign_ff;
      s3_e_ff    <= s2_e_ff;
      s3_m_ff    <= s3_m_in;
      s3_stk_ff  <= s3_stk_in;
      result_ff  <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/baro_temp_pressure_compensation_unit.sv @@
// Barometer temperature and pressure compensation, top level.
// Depends on bpc_pkg (types, microprogram) and bpc_fpu (shared binary32 unit).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  req     | in        | req_valid/req_stall  | req_func, req_raw
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_value, rsp_kind
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One transaction at a time. A microsequencer issues each binary32 operation
// to the single shared add/multiply unit and waits for its result before it
// issues the next: temperature runs 5 operations, pressure 24. The next request
// can be taken in the cycle after the result transaction leaves.
// Synchronous active-high reset clears coefficients and the stored linear
// temperature to +0.0. req_stall stays high from acceptance until the result
// transaction leaves; a stalled result holds in its output register.

module baro_temp_pressure_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [23:0] req_raw,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_kind,
   // configuration
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   bpc_pkg::seq_state_type state_ff, state_in;
   logic [4:0]  pc_ff, pc_in;
   logic        kind_ff, kind_in;
   logic [31:0] raw_f_ff, raw_f_in;
   logic [31:0] lin_ff, lin_in;
   logic [31:0] ra_ff, rb_ff, rc_ff, rd_ff, re_ff, rf_ff;
   logic [31:0] ra_in, rb_in, rc_in, rd_in, re_in, rf_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [63:0] coef_ff [7];
   logic [63:0] coef_in [7];

   bpc_pkg::step_type    step;
   bpc_pkg::fpu_req_type fpu_req;
   logic                 fpu_done;
   logic [31:0]          fpu_result;
   logic                 req_take;

   // Convert the unsigned 24-bit reading to binary32 (always exact).
   logic [4:0]  raw_lead;
   logic [23:0] raw_norm;
   logic [31:0] raw_float;

   always_comb begin
      raw_lead = '0;
      for (int i = 0; i < 24; i++) begin
         if (req_raw[i]) begin
            raw_lead = 5'(i);
         end
      end
      raw_norm = req_raw << (5'd23 - raw_lead);
      if (req_raw == '0) begin
         raw_float = '0;
      end else begin
         raw_float = {1'b0, 8'd127 + {3'b0, raw_lead}, raw_norm[22:0]};
      end
   end

   // Operand select.
   function automatic logic [31:0] pick(input bpc_pkg::src_type src,
                                        input logic [31:0] raw_v,
                                        input logic [31:0] lin_v,
                                        input logic [63:0] c0, input logic [63:0] c1,
                                        input logic [63:0] c2, input logic [63:0] c3,
                                        input logic [63:0] c4, input logic [63:0] c5,
                                        input logic [63:0] c6,
                                        input logic [31:0] va, input logic [31:0] vb,
                                        input logic [31:0] vc, input logic [31:0] vd,
                                        input logic [31:0] ve, input logic [31:0] vf);
      logic [31:0] v;
      unique case (src)
         bpc_pkg::SRC_RAW: v = raw_v;
         bpc_pkg::SRC_LIN: v = lin_v;
         bpc_pkg::SRC_T1:  v = c0[31:0];
         bpc_pkg::SRC_T2:  v = c0[63:32];
         bpc_pkg::SRC_T3:  v = c1[31:0];
         bpc_pkg::SRC_P1:  v = c1[63:32];
         bpc_pkg::SRC_P2:  v = c2[31:0];
         bpc_pkg::SRC_P3:  v = c2[63:32];
         bpc_pkg::SRC_P4:  v = c3[31:0];
         bpc_pkg::SRC_P5:  v = c3[63:32];
         bpc_pkg::SRC_P6:  v = c4[31:0];
         bpc_pkg::SRC_P7:  v = c4[63:32];
         bpc_pkg::SRC_P8:  v = c5[31:0];
         bpc_pkg::SRC_P9:  v = c5[63:32];
         bpc_pkg::SRC_P10: v = c6[31:0];
         bpc_pkg::SRC_P11: v = c6[63:32];
         bpc_pkg::SRC_RA:  v = va;
         bpc_pkg::SRC_RB:  v = vb;
         bpc_pkg::SRC_RC:  v = vc;
         bpc_pkg::SRC_RD:  v = vd;
         bpc_pkg::SRC_RE:  v = ve;
         bpc_pkg::SRC_RF:  v = vf;
         default:          v = '0;
      endcase
      return v;
   endfunction

   assign step     = bpc_pkg::prog_step(pc_ff);
   assign req_take = req_valid && (state_ff == bpc_pkg::ST_IDLE);

   // Sequencer: next state, issue and write-back.
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      kind_in      = kind_ff;
      raw_f_in     = raw_f_ff;
      lin_in       = lin_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rc_in        = rc_ff;
      rd_in        = rd_ff;
      re_in        = re_ff;
      rf_in        = rf_ff;
      rsp_value_in = rsp_value_ff;
      coef_in      = coef_ff;

      fpu_req.valid = 1'b0;
      fpu_req.op    = step.op;
      fpu_req.a     = pick(step.src_a, raw_f_ff, lin_ff, coef_ff[0], coef_ff[1],
                           coef_ff[2], coef_ff[3], coef_ff[4], coef_ff[5], coef_ff[6],
                           ra_ff, rb_ff, rc_ff, rd_ff, re_ff, rf_ff);
      fpu_req.b     = pick(step.src_b, raw_f_ff, lin_ff, coef_ff[0], coef_ff[1],
                           coef_ff[2], coef_ff[3], coef_ff[4], coef_ff[5], coef_ff[6],
                           ra_ff, rb_ff, rc_ff, rd_ff, re_ff, rf_ff);

      // configuration writes land at once; drop out-of-range indexes
      if (csr_wr_en && (csr_index <= bpc_pkg::CSR_P10_P11)) begin
         coef_in[csr_index] = csr_wdata;
      end

      unique case (state_ff)
         bpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bpc_pkg::ST_ISSUE;
               pc_in    = req_func ? bpc_pkg::PC_PRES : bpc_pkg::PC_TEMP;
               kind_in  = req_func;
               raw_f_in = raw_float;
            end
         end
         bpc_pkg::ST_ISSUE: begin
            fpu_req.valid = 1'b1;
            state_in      = bpc_pkg::ST_WAIT;
         end
         bpc_pkg::ST_WAIT: begin
            if (fpu_done) begin
               unique case (step.dst)
                  bpc_pkg::DST_RA:  ra_in  = fpu_result;
                  bpc_pkg::DST_RB:  rb_in  = fpu_result;
                  bpc_pkg::DST_RC:  rc_in  = fpu_result;
                  bpc_pkg::DST_RD:  rd_in  = fpu_result;
                  bpc_pkg::DST_RE:  re_in  = fpu_result;
                  bpc_pkg::DST_RF:  rf_in  = fpu_result;
                  bpc_pkg::DST_LIN: lin_in = fpu_result;
                  default:          ra_in  = ra_ff;
               endcase
               if (step.last) begin
                  rsp_value_in = fpu_result;
                  state_in     = bpc_pkg::ST_OUT;
               end else begin
                  pc_in    = pc_ff + 5'd1;
                  state_in = bpc_pkg::ST_ISSUE;
               end
            end
         end
         bpc_pkg::ST_OUT: begin
            // hold the result until the consumer takes it
            if (!rsp_stall) begin
               state_in = bpc_pkg::ST_IDLE;
            end
         end
         default: state_in = bpc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpc_pkg::ST_IDLE;
         pc_ff    <= '0;
         kind_ff  <= 1'b0;
         lin_ff   <= '0;
         for (int i = 0; i < 7; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         kind_ff  <= kind_in;
         lin_ff   <= lin_in;
         coef_ff  <= coef_in;
      end
      raw_f_ff     <= raw_f_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      rc_ff        <= rc_in;
      rd_ff        <= rd_in;
      re_ff        <= re_in;
      rf_ff        <= rf_in;
      rsp_value_ff <= rsp_value_in;
   end

   bpc_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .done   (fpu_done),
      .result (fpu_result)
   );

   assign req_stall = (state_ff != bpc_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == bpc_pkg::ST_OUT);
   assign rsp_value = rsp_value_ff;
   assign rsp_kind  = kind_ff;

   // An arithmetic result only returns while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> (state_ff == bpc_pkg::ST_WAIT))
      else $error("arithmetic result outside wait state");

   // An accepted transaction starts issuing on the next cycle.
   a_take_issue: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == bpc_pkg::ST_ISSUE))
      else $error("accepted transaction did not start");

   // Only a finished temperature program updates the stored linear temperature.
   a_lin_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(lin_ff) |-> ($past(state_ff) == bpc_pkg::ST_WAIT) && !kind_ff)
      else $error("linear temperature changed outside temperature write-back");

   // Issue is a single-cycle pulse followed by a wait.
   a_issue_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpc_pkg::ST_ISSUE) |=> (state_ff == bpc_pkg::ST_WAIT))
      else $error("issue not followed by wait");

endmodule
